/* src/gmap_pkg.sv */
// Package for the gated moving average point block.
// Field widths, register map, reset values and shared constants; no dependencies.
`default_nettype none

package gmap_pkg;

    localparam int COORD_W  = 16;
    localparam int GATE_W   = 12;
    localparam int WINDOW_W = 5;
    localparam int FILL_W   = 5;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int REG_IDX_W = 2;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_WEIGHTED = 2'd0;
    localparam t_reg_idx REG_GATE     = 2'd1;
    localparam t_reg_idx REG_WINDOW   = 2'd2;

    localparam logic                WEIGHTED_RESET = 1'b1;
    localparam logic [GATE_W-1:0]   GATE_RESET     = 12'd50;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 5'd16;

    // extra weight given to the newest point in weighted mode
    localparam int WEIGHT_EXTRA = 3;

    // gate radius is in whole pixels, coordinates carry four fraction bits
    localparam int FRAC_BITS = 4;

endpackage

`default_nettype wire

/* src/gmap_if.sv */
// Valid/ready channel interfaces for the point input and the result output.
// Depends on gmap_pkg for field widths.
`default_nettype none

interface gmap_in_if;
    logic                         valid;
    logic                         ready;
    logic [gmap_pkg::COORD_W-1:0] in_x;
    logic [gmap_pkg::COORD_W-1:0] in_y;

    modport source (output valid, output in_x, output in_y, input ready);
    modport sink   (input valid, input in_x, input in_y, output ready);
endinterface

interface gmap_out_if;
    logic                         valid;
    logic                         ready;
    logic [gmap_pkg::COORD_W-1:0] avg_x;
    logic [gmap_pkg::COORD_W-1:0] avg_y;
    logic [gmap_pkg::COORD_W-1:0] last_x;
    logic [gmap_pkg::COORD_W-1:0] last_y;
    logic                         accepted;
    logic [gmap_pkg::FILL_W-1:0]  fill;

    modport source (output valid, output avg_x, output avg_y, output last_x,
                    output last_y, output accepted, output fill, input ready);
    modport sink   (input valid, input avg_x, input avg_y, input last_x,
                    input last_y, input accepted, input fill, output ready);
endinterface

`default_nettype wire

/* src/gated_moving_average_point.sv */
// Gated moving average of 2-D points: top level with APB config, sequencer,
// bit-serial distance gate and bit-serial dividers. Uses gmap_pkg, gmap_if, gmap_ram.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  i_pt     | in  | valid/ready          | in_x, in_y
//  o_res    | out | valid/ready          | avg_x, avg_y, last_x, last_y, accepted, fill
//  apb      | in  | psel/penable, pready | paddr, pwdata, pwrite -> prdata
//
// One word at a time. A rejected point passes the serial squarer and the compare, then the result.
// An accepted point adds one read and one subtract per eviction, the append, the numerator and the
// serial divide; while at most one point is held, the gate pass is skipped.
// The dividers are restoring and produce one quotient bit per cycle.
// Reset is synchronous; window RAM is not cleared, only counted entries are read.
// A finished result waits in the output register; the next word is taken meanwhile.
`default_nettype none

module gated_moving_average_point #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    gmap_in_if.sink                                  i_pt,
    gmap_out_if.source                               o_res,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gmap_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [gmap_pkg::APB_DATA_W-1:0]     pwdata,
    output      logic [gmap_pkg::APB_DATA_W-1:0]     prdata,
    output      logic                                pready
);

    localparam int W    = gmap_pkg::COORD_W;
    localparam int PW   = $clog2(MAX_WINDOW);
    localparam int FW   = $clog2(MAX_WINDOW + 1);
    localparam int SUMW = W + FW;
    localparam int DW   = $clog2(MAX_WINDOW + gmap_pkg::WEIGHT_EXTRA + 1);
    localparam int NW   = W + DW;
    localparam int CW   = $clog2(W);
    localparam int GW   = gmap_pkg::GATE_W;
    localparam int WW   = gmap_pkg::WINDOW_W;

    typedef enum logic [3:0] {
        S_IDLE, S_GATE, S_CMP, S_EVRD, S_EVSUB, S_WRITE, S_NUM, S_DIV, S_DONE
    } t_state;

    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                              input logic          bit_in,
                                              input logic [DW-1:0] dvs);
        logic [DW:0] shifted;
        logic [DW:0] diff;
        shifted = {rem, bit_in};
        diff    = shifted - {1'b0, dvs};
        if (shifted >= {1'b0, dvs}) begin
            return {diff[DW-1:0], 1'b1};
        end
        return {shifted[DW-1:0], 1'b0};
    endfunction

    t_state r_state, n_state;

    logic          r_weighted, n_weighted;
    logic [GW-1:0] r_gate, n_gate;
    logic [WW-1:0] r_window, n_window;

    logic [W-1:0]    r_x, n_x, r_y, n_y;
    logic [PW-1:0]   r_ptr, n_ptr;
    logic [FW-1:0]   r_fill, n_fill, r_size, n_size;
    logic [SUMW-1:0] r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [W-1:0]    r_mean_x, n_mean_x, r_mean_y, n_mean_y;
    logic [W-1:0]    r_recent_x, n_recent_x, r_recent_y, n_recent_y;
    logic            r_acc, n_acc;
    logic [CW-1:0]   r_cnt, n_cnt;

    logic [2*W-1:0] r_mdx, n_mdx, r_mdy, n_mdy, r_mg, n_mg;
    logic [W-1:0]   r_bdx, n_bdx, r_bdy, n_bdy, r_bg, n_bg;
    logic [2*W:0]   r_accd, n_accd;
    logic [2*W-1:0] r_accg, n_accg;

    logic [DW-1:0] r_rem_x, n_rem_x, r_rem_y, n_rem_y, r_div, n_div;
    logic [W-1:0]  r_q_x, n_q_x, r_q_y, n_q_y;

    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_out_avg_x, n_out_avg_x, r_out_avg_y, n_out_avg_y;
    logic [W-1:0] r_out_last_x, n_out_last_x, r_out_last_y, n_out_last_y;
    logic         r_out_acc, n_out_acc;
    logic [gmap_pkg::FILL_W-1:0] r_out_fill, n_out_fill;

    logic              ram_we;
    logic [PW-1:0]     ram_waddr;
    logic [2*W-1:0]    ram_rdata;
    logic [PW:0]       pos_sum;
    logic [W-1:0]      dx, dy;
    logic [FW-1:0]     size_clamp;
    logic [NW-1:0]     num_x, num_y;
    logic [DW:0]       step_x, step_y;
    logic              cfg_wr;
    gmap_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[gmap_pkg::APB_ADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            gmap_pkg::REG_WEIGHTED: prdata = gmap_pkg::APB_DATA_W'(r_weighted);
            gmap_pkg::REG_GATE:     prdata = gmap_pkg::APB_DATA_W'(r_gate);
            gmap_pkg::REG_WINDOW:   prdata = gmap_pkg::APB_DATA_W'(r_window);
            default:                prdata = '0;
        endcase
    end

    assign dx = (i_pt.in_x > r_mean_x) ? i_pt.in_x - r_mean_x : r_mean_x - i_pt.in_x;
    assign dy = (i_pt.in_y > r_mean_y) ? i_pt.in_y - r_mean_y : r_mean_y - i_pt.in_y;

    always_comb begin
        if (r_window == '0) begin
            size_clamp = FW'(1);
        end else if (int'(r_window) > MAX_WINDOW) begin
            size_clamp = FW'(MAX_WINDOW);
        end else begin
            size_clamp = FW'(r_window);
        end
    end

    // slot after the newest point; ptr + fill stays below twice the depth
    assign pos_sum   = (PW+1)'(r_ptr) + (PW+1)'(r_fill);
    assign ram_waddr = (int'(pos_sum) >= MAX_WINDOW) ? PW'(pos_sum - (PW+1)'(MAX_WINDOW))
                                                     : PW'(pos_sum);
    assign ram_we    = (r_state == S_WRITE);

    assign num_x = NW'(r_sum_x) + (r_weighted ? NW'({r_recent_x, 1'b0}) + NW'(r_recent_x)
                                              : NW'(0));
    assign num_y = NW'(r_sum_y) + (r_weighted ? NW'({r_recent_y, 1'b0}) + NW'(r_recent_y)
                                              : NW'(0));

    assign step_x = div_step(r_rem_x, r_q_x[W-1], r_div);
    assign step_y = div_step(r_rem_y, r_q_y[W-1], r_div);

    gmap_ram #(
        .WIDTH (2*W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_x, r_y}),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_weighted = r_weighted;
        n_gate     = r_gate;
        n_window   = r_window;
        n_x        = r_x;
        n_y        = r_y;
        n_ptr      = r_ptr;
        n_fill     = r_fill;
        n_size     = r_size;
        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_mean_x   = r_mean_x;
        n_mean_y   = r_mean_y;
        n_recent_x = r_recent_x;
        n_recent_y = r_recent_y;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_mdx      = r_mdx;
        n_mdy      = r_mdy;
        n_mg       = r_mg;
        n_bdx      = r_bdx;
        n_bdy      = r_bdy;
        n_bg       = r_bg;
        n_accd     = r_accd;
        n_accg     = r_accg;
        n_rem_x    = r_rem_x;
        n_rem_y    = r_rem_y;
        n_div      = r_div;
        n_q_x      = r_q_x;
        n_q_y      = r_q_y;
        n_out_valid  = r_out_valid;
        n_out_avg_x  = r_out_avg_x;
        n_out_avg_y  = r_out_avg_y;
        n_out_last_x = r_out_last_x;
        n_out_last_y = r_out_last_y;
        n_out_acc    = r_out_acc;
        n_out_fill   = r_out_fill;

        if (cfg_wr) begin
            unique case (cfg_idx)
                gmap_pkg::REG_WEIGHTED: n_weighted = pwdata[0];
                gmap_pkg::REG_GATE:     n_gate     = pwdata[GW-1:0];
                gmap_pkg::REG_WINDOW:   n_window   = pwdata[WW-1:0];
                default:                n_weighted = r_weighted;
            endcase
        end

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    n_x    = i_pt.in_x;
                    n_y    = i_pt.in_y;
                    n_size = size_clamp;
                    n_mdx  = (2*W)'(dx);
                    n_mdy  = (2*W)'(dy);
                    n_bdx  = dx;
                    n_bdy  = dy;
                    n_mg   = (2*W)'({r_gate, gmap_pkg::FRAC_BITS'(0)});
                    n_bg   = W'({r_gate, gmap_pkg::FRAC_BITS'(0)});
                    n_accd = '0;
                    n_accg = '0;
                    n_cnt  = '0;
                    n_acc  = 1'b1;
                    n_state = (r_fill > FW'(1)) ? S_GATE : S_EVRD;
                end
            end
            S_GATE: begin
                n_accd = r_accd + (r_bdx[0] ? (2*W+1)'(r_mdx) : '0)
                                + (r_bdy[0] ? (2*W+1)'(r_mdy) : '0);
                n_accg = r_accg + (r_bg[0] ? r_mg : '0);
                n_mdx  = r_mdx << 1;
                n_mdy  = r_mdy << 1;
                n_mg   = r_mg << 1;
                n_bdx  = r_bdx >> 1;
                n_bdy  = r_bdy >> 1;
                n_bg   = r_bg >> 1;
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_accd > (2*W+1)'(r_accg)) begin
                    n_acc   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_EVRD;
                end
            end
            S_EVRD: begin
                // RAM read of the oldest slot is issued here
                n_state = (r_fill >= r_size) ? S_EVSUB : S_WRITE;
            end
            S_EVSUB: begin
                n_sum_x = r_sum_x - SUMW'(ram_rdata[2*W-1:W]);
                n_sum_y = r_sum_y - SUMW'(ram_rdata[W-1:0]);
                n_ptr   = (r_ptr == PW'(MAX_WINDOW - 1)) ? '0 : r_ptr + PW'(1);
                n_fill  = r_fill - FW'(1);
                n_state = S_EVRD;
            end
            S_WRITE: begin
                n_sum_x    = r_sum_x + SUMW'(r_x);
                n_sum_y    = r_sum_y + SUMW'(r_y);
                n_fill     = r_fill + FW'(1);
                n_recent_x = r_x;
                n_recent_y = r_y;
                n_state    = S_NUM;
            end
            S_NUM: begin
                n_rem_x = num_x[NW-1:W];
                n_rem_y = num_y[NW-1:W];
                n_q_x   = num_x[W-1:0];
                n_q_y   = num_y[W-1:0];
                n_div   = r_weighted ? DW'(r_fill) + DW'(gmap_pkg::WEIGHT_EXTRA)
                                     : DW'(r_fill);
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem_x = step_x[DW:1];
                n_rem_y = step_y[DW:1];
                n_q_x   = {r_q_x[W-2:0], step_x[0]};
                n_q_y   = {r_q_y[W-2:0], step_y[0]};
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_mean_x = {r_q_x[W-2:0], step_x[0]};
                    n_mean_y = {r_q_y[W-2:0], step_y[0]};
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_avg_x  = r_mean_x;
                    n_out_avg_y  = r_mean_y;
                    n_out_last_x = r_recent_x;
                    n_out_last_y = r_recent_y;
                    n_out_acc    = r_acc;
                    n_out_fill   = gmap_pkg::FILL_W'(r_fill);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_weighted  <= gmap_pkg::WEIGHTED_RESET;
            r_gate      <= gmap_pkg::GATE_RESET;
            r_window    <= gmap_pkg::WINDOW_RESET;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_mean_x    <= '0;
            r_mean_y    <= '0;
            r_recent_x  <= '0;
            r_recent_y  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_weighted  <= n_weighted;
            r_gate      <= n_gate;
            r_window    <= n_window;
            r_ptr       <= n_ptr;
            r_fill      <= n_fill;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_mean_x    <= n_mean_x;
            r_mean_y    <= n_mean_y;
            r_recent_x  <= n_recent_x;
            r_recent_y  <= n_recent_y;
            r_out_valid <= n_out_valid;
        end
        r_x          <= n_x;
        r_y          <= n_y;
        r_size       <= n_size;
        r_acc        <= n_acc;
        r_cnt        <= n_cnt;
        r_mdx        <= n_mdx;
        r_mdy        <= n_mdy;
        r_mg         <= n_mg;
        r_bdx        <= n_bdx;
        r_bdy        <= n_bdy;
        r_bg         <= n_bg;
        r_accd       <= n_accd;
        r_accg       <= n_accg;
        r_rem_x      <= n_rem_x;
        r_rem_y      <= n_rem_y;
        r_div        <= n_div;
        r_q_x        <= n_q_x;
        r_q_y        <= n_q_y;
        r_out_avg_x  <= n_out_avg_x;
        r_out_avg_y  <= n_out_avg_y;
        r_out_last_x <= n_out_last_x;
        r_out_last_y <= n_out_last_y;
        r_out_acc    <= n_out_acc;
        r_out_fill   <= n_out_fill;
    end

    assign i_pt.ready     = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.avg_x    = r_out_avg_x;
    assign o_res.avg_y    = r_out_avg_y;
    assign o_res.last_x   = r_out_last_x;
    assign o_res.last_y   = r_out_last_y;
    assign o_res.accepted = r_out_acc;
    assign o_res.fill     = r_out_fill;

    // divider remainder must stay below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem_x < r_div) && (r_rem_y < r_div))
        else $error("divider remainder out of range");

    // gate rejects only with at least two points held
    a_reject_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_acc) |-> (r_fill > FW'(1)))
        else $error("point rejected with fewer than two points");

    // append only into a free slot
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_fill < r_size))
        else $error("append into full window");

    // once a result went out the window is empty only between eviction and append
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_state != S_EVRD && r_state != S_WRITE) |-> (r_fill != '0))
        else $error("empty window after a result");

endmodule

`default_nettype wire

/* src/gmap_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gmap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
